// File: hdl/lssa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lssa_pkg
// Shared widths, reset values, codes and types of the level smoother.
// ----------------------------------------------------------------------------
package lssa_pkg;

	localparam int SAMPLE_BITS_DEF = 12;

	localparam int SEC_W      = 6;
	localparam int CNT_W      = 16;
	localparam int INT_W      = 15;
	localparam int CAL_W      = 12;
	localparam int ALM_W      = 7;
	localparam int LVL_W      = 24;
	localparam int Q_FRAC     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;

	// level*9 fits in 27 bits; /10 is a multiply by ceil(2^30/10) and a
	// shift right by 30, exact for any value below 2^27
	localparam int LVL9_W    = 27;
	localparam int EMA_MUL   = 9;
	localparam int EMA_DIV   = 10;
	localparam int EMA_SHIFT = 30;
	localparam logic [LVL9_W-1:0] EMA_RECIP = LVL9_W'(107374183);

	// sample term scale: 2560 = 10 * 256, needs 12 bits
	localparam int TERM_SCALE   = 2560;
	localparam int TERM_SCALE_W = 12;

	localparam int HYST_PCT = 5;

	localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
	localparam logic [LVL_W-1:0] LVL_RESET = LVL_W'(12800);
	localparam logic [LVL_W-1:0] LVL_MAX   = {1'b0, {(LVL_W-1){1'b1}}};
	localparam logic [LVL_W-1:0] LVL_MIN   = {1'b1, {(LVL_W-1){1'b0}}};

	localparam logic [CAL_W-1:0] RAW_EMPTY_RST = CAL_W'(0);
	localparam logic [CAL_W-1:0] RAW_FULL_RST  = CAL_W'(1024);
	localparam logic [ALM_W-1:0] ALARM_RST     = ALM_W'(0);
	localparam logic [INT_W-1:0] INTERVAL_RST  = INT_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RAW_EMPTY     = 2'd0,
		CFG_RAW_FULL      = 2'd1,
		CFG_ALARM_LEVEL   = 2'd2,
		CFG_READ_INTERVAL = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [CAL_W-1:0] raw_empty;
		logic [CAL_W-1:0] raw_full;
		logic [ALM_W-1:0] alarm_level;
		logic [INT_W-1:0] read_interval;
	} cfg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_SUM,
		BK_ALARM,
		BK_OUT
	} back_state_t;

endpackage

`default_nettype wire

// File: hdl/lssa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lssa_front
// Accepts items, tracks second changes and decides whether a sample is taken.
// ----------------------------------------------------------------------------
module lssa_front #(
	parameter int SAMPLE_BITS = lssa_pkg::SAMPLE_BITS_DEF
) (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             item_valid,
	output logic                            item_stall,
	input  wire  [lssa_pkg::SEC_W-1:0]      second_now,
	input  wire  [SAMPLE_BITS-1:0]          sample_raw,
	input  wire  [lssa_pkg::INT_W-1:0]      read_interval,
	input  wire                             q_full,
	output logic                            push,
	output logic [SAMPLE_BITS:0]            push_data
);

	logic [lssa_pkg::SEC_W-1:0] prev_second_q;
	logic [lssa_pkg::CNT_W-1:0] second_count_q;
	logic [lssa_pkg::CNT_W-1:0] count_adv;
	logic                       taken;

	assign item_stall = q_full;
	assign push       = item_valid & ~q_full;

	always_comb begin
		count_adv = second_count_q;
		if (second_now != prev_second_q && second_count_q != lssa_pkg::CNT_MAX) begin
			count_adv = second_count_q + 1'b1;
		end
		taken = count_adv >= {1'b0, read_interval};
	end

	assign push_data = {taken, sample_raw};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_second_q  <= '0;
			second_count_q <= '0;
		end else if (push) begin
			prev_second_q  <= second_now;
			second_count_q <= taken ? '0 : count_adv;
		end
	end

endmodule

`default_nettype wire

// File: hdl/lssa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lssa_queue
// Two-entry queue between the classifying front and the arithmetic back.
// ----------------------------------------------------------------------------
module lssa_queue #(
	parameter int W = lssa_pkg::SAMPLE_BITS_DEF + 1
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          push,
	input  wire  [W-1:0] push_data,
	output logic         full,
	input  wire          pop,
	output logic         pop_valid,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] entry_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   fill_q;

	assign full      = fill_q[1];
	assign pop_valid = fill_q != 2'd0;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hdl/lssa_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lssa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lssa_div #(
	parameter int NUM_W = 24,
	parameter int DEN_W = 12
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	input  wire  [NUM_W-1:0] num,
	input  wire  [DEN_W-1:0] den,
	output logic             busy,
	output logic [NUM_W-1:0] quo
);

	localparam int CW = $clog2(NUM_W + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   trial;
	logic             fits;

	assign busy    = cnt_q != '0;
	assign quo     = quo_q;
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy) begin
			rem_q <= fits ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// File: hdl/lssa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lssa_back
// Folds taken samples into the moving average unless the calibration points
// are equal, updates the alarm and registers one result per transaction.
// ----------------------------------------------------------------------------
module lssa_back #(
	parameter int SAMPLE_BITS = lssa_pkg::SAMPLE_BITS_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  lssa_pkg::cfg_t                     cfg,
	input  wire                                q_valid,
	input  wire  [SAMPLE_BITS:0]               q_data,
	output logic                               q_pop,
	output logic                               result_valid,
	input  wire                                result_stall,
	output logic [lssa_pkg::LVL_W-1:0]         level_q8,
	output logic                               alarm_on,
	output logic [SAMPLE_BITS-1:0]             last_raw,
	output logic                               sample_taken
);

	localparam int SB    = SAMPLE_BITS;
	localparam int NUM_W = SB + lssa_pkg::TERM_SCALE_W;
	localparam int MAX_W = (NUM_W > lssa_pkg::LVL9_W) ? NUM_W : lssa_pkg::LVL9_W;
	localparam int SUM_W = MAX_W + 2;
	localparam int LW    = lssa_pkg::LVL_W;
	localparam int THR_PAD = LW - lssa_pkg::ALM_W - 1 - lssa_pkg::Q_FRAC;
	localparam int PROD_W  = 2 * lssa_pkg::LVL9_W;

	lssa_pkg::back_state_t state_q, state_d;

	logic                  q_taken;
	logic [SB-1:0]         q_raw;
	logic                  div_start;
	logic                  load_out;
	logic                  out_free;
	logic                  busy_term;
	logic [NUM_W-1:0]      quo_term;

	logic [SB+lssa_pkg::CAL_W-1:0] empty_ext, full_ext;
	logic [SB-1:0]         empty_eff, full_eff;
	logic [SB:0]           span, span_neg, diff, diff_neg;
	logic [SB-1:0]         span_mag, diff_mag;
	logic                  span_zero;
	logic [NUM_W-1:0]      num_term;
	logic [LW-1:0]         lvl_neg, lvl_mag;
	logic [lssa_pkg::LVL9_W-1:0] lvl9;
	logic [lssa_pkg::LVL9_W-1:0] lvl9_q;
	logic [PROD_W-1:0]     lvl_prod;
	logic [LW-1:0]         lvl_quo_q;

	logic [SUM_W-1:0]      lvl_u, term_u, lvl_part, term_part, sum;
	logic                  sum_fits;
	logic [LW-1:0]         sum_sat;
	logic signed [LW-1:0]  thr_set, thr_clr;
	logic [lssa_pkg::ALM_W:0] alarm_hi;

	logic signed [LW-1:0]  smoothed_q;
	logic                  alarm_q;
	logic [SB-1:0]         held_q;
	logic                  taken_q;
	logic                  lvl_neg_q, term_neg_q;
	logic                  out_valid_q;
	logic [LW-1:0]         out_level_q;
	logic                  out_alarm_q;
	logic [SB-1:0]         out_raw_q;
	logic                  out_taken_q;

	assign q_taken = q_data[SB];
	assign q_raw   = q_data[SB-1:0];

	// calibration points are taken at the sample width
	assign empty_ext = {{SB{1'b0}}, cfg.raw_empty};
	assign full_ext  = {{SB{1'b0}}, cfg.raw_full};
	assign empty_eff = empty_ext[SB-1:0];
	assign full_eff  = full_ext[SB-1:0];

	assign span      = {1'b0, full_eff} - {1'b0, empty_eff};
	assign span_neg  = -span;
	assign span_mag  = span[SB] ? span_neg[SB-1:0] : span[SB-1:0];
	assign span_zero = full_eff == empty_eff;
	assign diff      = {1'b0, q_raw} - {1'b0, empty_eff};
	assign diff_neg  = -diff;
	assign diff_mag  = diff[SB] ? diff_neg[SB-1:0] : diff[SB-1:0];
	assign num_term  = NUM_W'(diff_mag) * NUM_W'(lssa_pkg::TERM_SCALE);

	assign lvl_neg = -smoothed_q;
	assign lvl_mag = smoothed_q[LW-1] ? lvl_neg : smoothed_q;
	assign lvl9    = lssa_pkg::LVL9_W'(lvl_mag) * lssa_pkg::LVL9_W'(lssa_pkg::EMA_MUL);

	// level*9/10 by reciprocal multiplication while the term divider runs
	assign lvl_prod = PROD_W'(lvl9_q) * PROD_W'(lssa_pkg::EMA_RECIP);

	lssa_div #(
		.NUM_W (NUM_W),
		.DEN_W (SB)
	) u_div_term (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_term),
		.den    (span_mag),
		.busy   (busy_term),
		.quo    (quo_term)
	);

	assign lvl_u     = SUM_W'(lvl_quo_q);
	assign term_u    = SUM_W'(quo_term);
	assign lvl_part  = lvl_neg_q ? -lvl_u : lvl_u;
	assign term_part = term_neg_q ? -term_u : term_u;
	assign sum       = lvl_part + term_part;
	assign sum_fits  = (&sum[SUM_W-1:LW-1]) | ~(|sum[SUM_W-1:LW-1]);
	assign sum_sat   = sum_fits ? sum[LW-1:0] :
		(sum[SUM_W-1] ? lssa_pkg::LVL_MIN : lssa_pkg::LVL_MAX);

	assign alarm_hi = {1'b0, cfg.alarm_level} + (lssa_pkg::ALM_W + 1)'(lssa_pkg::HYST_PCT);
	assign thr_set  = {{(THR_PAD + 1){1'b0}}, cfg.alarm_level, {lssa_pkg::Q_FRAC{1'b0}}};
	assign thr_clr  = {{THR_PAD{1'b0}}, alarm_hi, {lssa_pkg::Q_FRAC{1'b0}}};

	assign out_free = ~out_valid_q | ~result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lssa_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			lssa_pkg::BK_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (!q_taken) begin
						state_d = lssa_pkg::BK_OUT;
					end else if (span_zero) begin
						state_d = lssa_pkg::BK_ALARM;
					end else begin
						div_start = 1'b1;
						state_d   = lssa_pkg::BK_DIV;
					end
				end
			end
			lssa_pkg::BK_DIV: begin
				if (!busy_term) begin
					state_d = lssa_pkg::BK_SUM;
				end
			end
			lssa_pkg::BK_SUM: begin
				state_d = lssa_pkg::BK_ALARM;
			end
			lssa_pkg::BK_ALARM: begin
				state_d = lssa_pkg::BK_OUT;
			end
			lssa_pkg::BK_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = lssa_pkg::BK_IDLE;
				end
			end
			default: begin
				state_d = lssa_pkg::BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smoothed_q  <= lssa_pkg::LVL_RESET;
			alarm_q     <= 1'b0;
			held_q      <= '0;
			taken_q     <= 1'b0;
			lvl_neg_q   <= 1'b0;
			term_neg_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				taken_q    <= q_taken;
				lvl_neg_q  <= smoothed_q[LW-1];
				term_neg_q <= diff[SB] ^ span[SB];
				if (q_taken) begin
					held_q <= q_raw;
				end
			end
			if (state_q == lssa_pkg::BK_SUM) begin
				smoothed_q <= sum_sat;
			end
			if (state_q == lssa_pkg::BK_ALARM) begin
				if (alarm_q) begin
					alarm_q <= ~(smoothed_q > thr_clr);
				end else begin
					alarm_q <= smoothed_q < thr_set;
				end
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			lvl9_q <= lvl9;
		end
		if (state_q == lssa_pkg::BK_DIV) begin
			lvl_quo_q <= lvl_prod[lssa_pkg::EMA_SHIFT +: LW];
		end
		if (load_out) begin
			out_level_q <= smoothed_q;
			out_alarm_q <= alarm_q;
			out_raw_q   <= held_q;
			out_taken_q <= taken_q;
		end
	end

	assign result_valid = out_valid_q;
	assign level_q8     = out_level_q;
	assign alarm_on     = out_alarm_q;
	assign last_raw     = out_raw_q;
	assign sample_taken = out_taken_q;

endmodule

`default_nettype wire

// File: hdl/level_sensor_smoother_alarm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// level_sensor_smoother_alarm
// Level sensor smoother: interval sampling, Q8 moving average, hysteresis
// alarm.
// ----------------------------------------------------------------------------
// Each item gives one result. The front counts second changes and marks an
// item as a taken sample, then hands it through a two-entry queue to the
// back, so items are still accepted until the queue is full while a result
// waits on result_stall. An item without a sample goes straight to the output
// state of the back; a taken sample waits on the serial divider that forms
// the calibration term, then updates the level and the alarm; level*9/10 is
// a reciprocal multiplication that finishes while that divider runs. With
// equal calibration points the divider and the sum are skipped. Configuration
// registers are written through cfg_valid/cfg_ready and must only be changed
// while no transaction is in flight.
// ----------------------------------------------------------------------------
module level_sensor_smoother_alarm #(
	parameter int SAMPLE_BITS = lssa_pkg::SAMPLE_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire  [lssa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [lssa_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire                                  item_valid,
	output logic                                 item_stall,
	input  wire  [lssa_pkg::SEC_W-1:0]           second_now,
	input  wire  [SAMPLE_BITS-1:0]               sample_raw,
	output logic                                 result_valid,
	input  wire                                  result_stall,
	output logic [lssa_pkg::LVL_W-1:0]           level_q8,
	output logic                                 alarm_on,
	output logic [SAMPLE_BITS-1:0]               last_raw,
	output logic                                 sample_taken
);

	lssa_pkg::cfg_t cfg_q;

	logic                 push, q_full, q_pop, q_valid;
	logic [SAMPLE_BITS:0] push_data, q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.raw_empty     <= lssa_pkg::RAW_EMPTY_RST;
			cfg_q.raw_full      <= lssa_pkg::RAW_FULL_RST;
			cfg_q.alarm_level   <= lssa_pkg::ALARM_RST;
			cfg_q.read_interval <= lssa_pkg::INTERVAL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (lssa_pkg::cfg_idx_t'(cfg_index))
				lssa_pkg::CFG_RAW_EMPTY:     cfg_q.raw_empty <= cfg_data[lssa_pkg::CAL_W-1:0];
				lssa_pkg::CFG_RAW_FULL:      cfg_q.raw_full <= cfg_data[lssa_pkg::CAL_W-1:0];
				lssa_pkg::CFG_ALARM_LEVEL:   cfg_q.alarm_level <= cfg_data[lssa_pkg::ALM_W-1:0];
				lssa_pkg::CFG_READ_INTERVAL: cfg_q.read_interval <= cfg_data[lssa_pkg::INT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	lssa_front #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.second_now    (second_now),
		.sample_raw    (sample_raw),
		.read_interval (cfg_q.read_interval),
		.q_full        (q_full),
		.push          (push),
		.push_data     (push_data)
	);

	lssa_queue #(
		.W (SAMPLE_BITS + 1)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	lssa_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_valid      (q_valid),
		.q_data       (q_data),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.level_q8     (level_q8),
		.alarm_on     (alarm_on),
		.last_raw     (last_raw),
		.sample_taken (sample_taken)
	);

endmodule

`default_nettype wire

// File: hdl/lssa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lssa_checker
// Port-level checks of the level smoother, bound to the top level.
// ----------------------------------------------------------------------------
module lssa_checker #(
	parameter int SAMPLE_BITS = lssa_pkg::SAMPLE_BITS_DEF
) (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              cfg_ready,
	input wire                              result_valid,
	input wire                              result_stall,
	input wire [lssa_pkg::LVL_W-1:0]        level_q8,
	input wire                              alarm_on,
	input wire [SAMPLE_BITS-1:0]            last_raw,
	input wire                              sample_taken
);

	// a stalled result transaction stays offered
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result valid dropped while stalled");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(level_q8) && $stable(alarm_on) &&
			$stable(last_raw) && $stable(sample_taken))
		else $error("stalled result payload changed");

	// thresholds are never negative, so a negative level after a sample alarms
	a_neg_alarm: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && sample_taken && level_q8[lssa_pkg::LVL_W-1] |-> alarm_on)
		else $error("negative level without alarm");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind level_sensor_smoother_alarm lssa_checker #(
	.SAMPLE_BITS (SAMPLE_BITS)
) u_lssa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cfg_ready    (cfg_ready),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.level_q8     (level_q8),
	.alarm_on     (alarm_on),
	.last_raw     (last_raw),
	.sample_taken (sample_taken)
);

`default_nettype wire
